// ----- src/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Register map (index of a 32-bit register, byte address 4*index)
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  localparam int unsigned ADDR_W = 3;

  localparam logic        DIR_ENCODE     = 1'b0;
  localparam logic [15:0] CAPACITY_RESET = 16'hffff;
  localparam logic [15:0] COUNT_MAX      = 16'hffff;

  localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // Depth of the record queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_last;
    logic        out_status;
    logic [15:0] out_total;
  } result_t;

  // One classified item: up to four output bytes plus stream bookkeeping
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      num;     // data bytes carried, 0..4
    logic            last;    // item closes the stream
    logic            status;  // overflow status for every result of this item
    logic [15:0]     base;    // emitted count before this item
  } rec_t;

  // Sextet to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(8'h41 + {2'b00, v});
    end else if (v < 6'd52) begin
      c = 8'(8'h61 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(8'h30 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // Alphabet character to {valid, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5a]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7a]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- src/base64_stream_codec.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder with a register port for mode and capacity.
// ----------------------------------------------------------------------------
// The first result of an item passes through the record queue and then the
// output register before it is on the result ports.
// Throughput: one item per cycle into the record queue while it is not full, one
// result per cycle out of the output register while the receiver pops; an encode
// item gives 1 to 4 results, so the result port sets the sustained rate.
// Reset (synchronous): stream state and queue cleared, direction encode,
// capacity 65535.
module base64_stream_codec import b64_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  item_t             item,
  input  logic              pop,
  output logic              empty,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        direction;
  logic [15:0] out_capacity;
  logic        cfg_wr;
  logic        accept;
  logic        rec_push, rec_pop, rec_avail;
  rec_t        rec_in, rec_out;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_ENCODE;
      out_capacity <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DIRECTION) begin
        direction <= pwdata[0];
      end else begin
        out_capacity <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {16'd0, out_capacity};
    end else begin
      prdata = {31'd0, direction};
    end
  end

  assign accept = push && !full;

  b64_front u_front (
    .clk          (clk),
    .rst          (rst),
    .direction    (direction),
    .out_capacity (out_capacity),
    .accept       (accept),
    .item         (item),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .full    (full),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .avail   (rec_avail)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_avail (rec_avail),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ----- src/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front
// Accepts items, runs the encode/decode state, records data or closing items.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        direction,
  input  logic [15:0] out_capacity,
  input  logic        accept,
  input  item_t       item,
  output logic        rec_push,
  output rec_t        rec
);

  logic [13:0] bit_store, bit_store_next;
  logic [3:0]  bit_fill, bit_fill_next;
  logic [1:0]  group_phase, group_phase_next;
  logic [15:0] emitted_count, emitted_count_next;
  logic        pad_seen, pad_seen_next;
  logic        overflowed, overflowed_next;

  logic [3:0][7:0] chars;
  logic [2:0]      num;
  logic [6:0]      sext;
  logic [13:0]     st;
  logic [4:0]      fl;
  logic [4:0]      fl2;
  logic [16:0]     cnt_sum;
  logic [7:0]      b;
  logic            item_status;

  assign b    = item.in_byte;
  assign sext = b64_sextet(b);

  // Work out the item
  always_comb begin
    bit_store_next   = bit_store;
    bit_fill_next    = bit_fill;
    group_phase_next = group_phase;
    pad_seen_next    = pad_seen;
    overflowed_next  = overflowed;
    chars            = '0;
    num              = 3'd0;
    st               = {bit_store[7:0], sext[5:0]};
    fl               = {1'b0, bit_fill} + 5'd6;
    fl2              = fl - 5'd8;

    if (direction != DIR_ENCODE) begin
      // decode: gather sextets, emit a byte once eight bits are held
      if (!pad_seen && !overflowed) begin
        if (b == PAD_CHAR || b == NUL_CHAR) begin
          pad_seen_next = 1'b1;
        end else if (sext[6]) begin
          if (fl >= 5'd8) begin
            if (emitted_count >= out_capacity) begin
              overflowed_next = 1'b1;
              bit_store_next  = '0;
              bit_fill_next   = '0;
            end else begin
              chars[0]       = 8'(st >> fl2[3:0]);
              num            = 3'd1;
              bit_store_next = st & ((14'd1 << fl2[3:0]) - 14'd1);
              bit_fill_next  = fl2[3:0];
            end
          end else begin
            bit_store_next = st;
            bit_fill_next  = fl[3:0];
          end
        end
      end
    end else begin
      // encode: emit each character as soon as its six bits are known
      case (group_phase)
        2'd1: begin
          chars[0]         = b64_char({bit_store[1:0], b[7:4]});
          num              = 3'd1;
          bit_store_next   = {10'd0, b[3:0]};
          group_phase_next = 2'd2;
        end
        2'd2: begin
          chars[0]         = b64_char({bit_store[3:0], b[7:6]});
          chars[1]         = b64_char(b[5:0]);
          num              = 3'd2;
          bit_store_next   = '0;
          group_phase_next = 2'd0;
        end
        default: begin
          chars[0]         = b64_char(b[7:2]);
          num              = 3'd1;
          bit_store_next   = {12'd0, b[1:0]};
          group_phase_next = 2'd1;
        end
      endcase
      // finish a partial group with padding
      if (item.in_last) begin
        if (group_phase_next == 2'd1) begin
          chars[1] = b64_char({b[1:0], 4'd0});
          chars[2] = PAD_CHAR;
          chars[3] = PAD_CHAR;
          num      = 3'd4;
        end else if (group_phase_next == 2'd2) begin
          chars[1] = b64_char({b[3:0], 2'd0});
          chars[2] = PAD_CHAR;
          num      = 3'd3;
        end
      end
    end

    cnt_sum            = {1'b0, emitted_count} + {14'd0, num};
    emitted_count_next = cnt_sum[16] ? COUNT_MAX : cnt_sum[15:0];

    // status as it stands once the item is done, before the stream closes
    item_status = overflowed_next;

    // close the stream
    if (item.in_last) begin
      bit_store_next     = '0;
      bit_fill_next      = '0;
      group_phase_next   = '0;
      emitted_count_next = '0;
      pad_seen_next      = 1'b0;
      overflowed_next    = 1'b0;
    end
  end

  // Build the record
  always_comb begin
    rec.bytes  = chars;
    rec.num    = num;
    rec.last   = item.in_last;
    rec.status = item_status;
    rec.base   = emitted_count;
    rec_push   = accept && (num != 3'd0 || item.in_last);
  end

  // Hold stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store     <= '0;
      bit_fill      <= '0;
      group_phase   <= '0;
      emitted_count <= '0;
      pad_seen      <= 1'b0;
      overflowed    <= 1'b0;
    end else if (accept) begin
      bit_store     <= bit_store_next;
      bit_fill      <= bit_fill_next;
      group_phase   <= group_phase_next;
      emitted_count <= emitted_count_next;
      pad_seen      <= pad_seen_next;
      overflowed    <= overflowed_next;
    end
  end

endmodule

// ----- src/b64_queue.sv -----
// ----------------------------------------------------------------------------
// b64_queue
// Short record queue between the front and the back.
// ----------------------------------------------------------------------------
module b64_queue import b64_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  rec_t wr_data,
  output logic full,
  input  logic rd_en,
  output rec_t rd_data,
  output logic avail
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_FULL);
  assign avail   = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && avail;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back
// Unpacks each record into results, one per cycle while the receiver pops, into the output register.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    rec_avail,
  input  rec_t    rec,
  output logic    rec_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  logic [1:0]  idx;
  logic [1:0]  idx_last;
  logic        res_valid;
  result_t     res_q, res_next;
  logic        load;
  logic [16:0] tot_sum;

  assign load     = rec_avail && (!res_valid || pop);
  assign idx_last = (rec.num == 3'd0) ? 2'd0 : 2'(rec.num - 3'd1);
  assign rec_pop  = load && (idx == idx_last);
  assign tot_sum  = {1'b0, rec.base} + {15'd0, idx} + 17'd1;

  // Form the next result
  always_comb begin
    res_next.out_byte   = (rec.num == 3'd0) ? 8'd0 : rec.bytes[idx];
    res_next.out_valid  = (rec.num != 3'd0);
    res_next.out_last   = rec.last && (idx == idx_last);
    res_next.out_status = rec.status;
    if (rec.num == 3'd0) begin
      res_next.out_total = rec.base;
    end else begin
      res_next.out_total = tot_sum[16] ? COUNT_MAX : tot_sum[15:0];
    end
  end

  // Hold the output register and walk the record
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= rec_pop ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_next;
    end
  end

  assign result = res_q;
  assign empty  = !res_valid;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 stream codec. Streams of bytes and
// characters go in through the input queue port. The register port sets
// direction and capacity between phases. A scoreboard predicts every result
// and checks results in order as they are popped.
// ----------------------------------------------------------------------------

class b64_scoreboard;

  string        b64_alphabet;
  logic         direction;
  logic [15:0]  capacity;

  // Stream state, cleared after every closing result
  logic [13:0]  bit_store;
  logic [3:0]   bit_fill;
  logic [1:0]   group_phase;
  logic [15:0]  emitted;
  logic         pad_seen;
  logic         overflowed;

  b64_pkg::result_t pending_results[$];
  int           errors;
  int           reported;

  function new();
    b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    direction    = b64_pkg::DIR_ENCODE;
    capacity     = b64_pkg::CAPACITY_RESET;
    errors       = 0;
    reported     = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    bit_store   = '0;
    bit_fill    = '0;
    group_phase = '0;
    emitted     = '0;
    pad_seen    = 1'b0;
    overflowed  = 1'b0;
  endfunction

  function void set_register(logic idx, logic [31:0] value);
    if (idx == b64_pkg::REG_DIRECTION) begin
      direction = value[0];
    end else begin
      capacity = value[15:0];
    end
  endfunction

  function logic [7:0] sextet_char(logic [5:0] v);
    return b64_alphabet[v];
  endfunction

  // Append one data result, counting it first (count sticks at its maximum)
  function void emit_byte(logic [7:0] b);
    b64_pkg::result_t r;
    if (emitted != b64_pkg::COUNT_MAX) emitted = emitted + 16'd1;
    r.out_byte   = b;
    r.out_valid  = 1'b1;
    r.out_last   = 1'b0;
    r.out_status = overflowed;
    r.out_total  = emitted;
    pending_results.push_back(r);
  endfunction

  function void encode_byte(logic [7:0] b, logic is_last);
    case (group_phase)
      2'd1: begin
        emit_byte(sextet_char({bit_store[1:0], b[7:4]}));
        bit_store   = {10'd0, b[3:0]};
        group_phase = 2'd2;
      end
      2'd2: begin
        emit_byte(sextet_char({bit_store[3:0], b[7:6]}));
        emit_byte(sextet_char(b[5:0]));
        bit_store   = '0;
        group_phase = 2'd0;
      end
      default: begin
        // phase three never arises and behaves as phase zero
        emit_byte(sextet_char(b[7:2]));
        bit_store   = {12'd0, b[1:0]};
        group_phase = 2'd1;
      end
    endcase
    // Finish a partial group with padding
    if (is_last) begin
      if (group_phase == 2'd1) begin
        emit_byte(sextet_char({bit_store[1:0], 4'd0}));
        emit_byte(b64_pkg::PAD_CHAR);
        emit_byte(b64_pkg::PAD_CHAR);
      end else if (group_phase == 2'd2) begin
        emit_byte(sextet_char({bit_store[3:0], 2'd0}));
        emit_byte(b64_pkg::PAD_CHAR);
      end
    end
  endfunction

  function void decode_char(logic [7:0] c);
    int sextet;
    if (pad_seen || overflowed) return;
    if (c == b64_pkg::PAD_CHAR || c == b64_pkg::NUL_CHAR) begin
      pad_seen = 1'b1;
      return;
    end
    if (c >= "A" && c <= "Z") sextet = int'(c - "A");
    else if (c >= "a" && c <= "z") sextet = int'(c - "a") + 26;
    else if (c >= "0" && c <= "9") sextet = int'(c - "0") + 52;
    else if (c == "+") sextet = 62;
    else if (c == "/") sextet = 63;
    else sextet = -1;
    // Skip characters outside the alphabet
    if (sextet < 0) return;
    bit_store = {bit_store[7:0], 6'(sextet)};
    bit_fill  = bit_fill + 4'd6;
    if (bit_fill >= 4'd8) begin
      bit_fill = bit_fill - 4'd8;
      if (emitted >= capacity) begin
        overflowed = 1'b1;
        bit_store  = '0;
        bit_fill   = '0;
        return;
      end
      emit_byte(8'(bit_store >> bit_fill));
      bit_store = bit_store & ((14'd1 << bit_fill) - 14'd1);
    end
  endfunction

  // Predict the results of one accepted input transaction
  function void note_item(b64_pkg::item_t it);
    int base_n;
    b64_pkg::result_t r;
    base_n = pending_results.size();
    if (direction != b64_pkg::DIR_ENCODE) begin
      decode_char(it.in_byte);
    end else begin
      encode_byte(it.in_byte, it.in_last);
    end
    if (it.in_last) begin
      if (pending_results.size() > base_n) begin
        // last data result doubles as the closing result
        r = pending_results.pop_back();
        r.out_last   = 1'b1;
        r.out_status = overflowed;
        pending_results.push_back(r);
      end else begin
        r            = '0;
        r.out_last   = 1'b1;
        r.out_status = overflowed;
        r.out_total  = emitted;
        pending_results.push_back(r);
      end
      clear_stream();
    end
  endfunction

  // Compare one popped result with the oldest prediction
  function void check_result(b64_pkg::result_t got);
    b64_pkg::result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (reported < 10) begin
        $display("unexpected result: byte=%02h valid=%0d last=%0d status=%0d total=%0d",
                 got.out_byte, got.out_valid, got.out_last, got.out_status, got.out_total);
        reported++;
      end
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      errors++;
      if (reported < 10) begin
        $display("result mismatch: expected byte=%02h valid=%0d last=%0d status=%0d total=%0d",
                 want.out_byte, want.out_valid, want.out_last, want.out_status,
                 want.out_total);
        $display("                 actual   byte=%02h valid=%0d last=%0d status=%0d total=%0d",
                 got.out_byte, got.out_valid, got.out_last, got.out_status, got.out_total);
        reported++;
      end
    end
  endfunction

endclass

module testbench;
  import b64_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              push;
  logic              full;
  item_t             in_item;
  logic              pop;
  logic              empty;
  result_t           out_result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  b64_scoreboard sb;
  bit            tx_idle_en;
  bit            rx_idle_en;
  int            rx_hold_cycles;

  base64_stream_codec u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (in_item),
    .pop     (pop),
    .empty   (empty),
    .result  (out_result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Hard limit on the run
  initial begin
    #24000000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one input transaction, after a random gap when idling is enabled; hold it until accepted
  task automatic send_item(input logic [7:0] value, input logic is_last);
    int    gap;
    item_t it;
    it.in_byte = value;
    it.in_last = is_last;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Stop offering, let every predicted result drain, then allow for latency
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
    end
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    readback = (idx == REG_DIRECTION) ? {31'd0, value[0]} : {16'd0, value[15:0]};
    if (prdata !== readback) begin
      sb.errors++;
      if (sb.reported < 10) begin
        $display("register readback mismatch at %0h: expected %08h actual %08h",
                 {idx, 2'b00}, readback, prdata);
        sb.reported++;
      end
    end
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    // leave the port idle before the next access
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [15:0] cap;
    int          pick;
    wait_idle();
    write_reg(REG_DIRECTION, {31'd0, 1'($urandom_range(0, 1))});
    pick = $urandom_range(0, 9);
    if (pick < 3) cap = CAPACITY_RESET;
    else if (pick < 5) cap = 16'($urandom_range(0, 3));
    else if (pick < 8) cap = 16'($urandom_range(4, 12));
    else cap = 16'($urandom);
    write_reg(REG_CAPACITY, {16'd0, cap});
  endtask

  // Mostly well-formed base64 text when decoding, with noise, pads and NULs
  function automatic logic [7:0] random_char(input bit at_end);
    int pick;
    if (sb.direction == DIR_ENCODE) return 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < (at_end ? 50 : 85)) return sb.b64_alphabet[$urandom_range(0, 63)];
    if (pick < (at_end ? 75 : 93)) return 8'($urandom);
    if (at_end || pick < 98) return PAD_CHAR;
    return NUL_CHAR;
  endfunction

  // Random streams, with config changes between streams and direction flips
  // inside some of them
  task automatic run_streams(input int n_items);
    int sent;
    int len;
    int split;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) random_config();
      len   = $urandom_range(1, 16);
      split = (len > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int i = 0; i < len; i++) begin
        if (split != 0 && i == split) begin
          wait_idle();
          write_reg(REG_DIRECTION, {31'd0, ~sb.direction});
        end
        send_item(random_char(i == len - 1), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Result side: pop with random stalls, plus a long hold-off on request
  initial begin : result_sink
    int gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      sb.check_result(out_result);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    push           = 1'b0;
    in_item        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    sb             = new();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);

    // Encode: one byte (two pads), two bytes (one pad), full group of 62/63
    write_reg(REG_DIRECTION, {31'd0, DIR_ENCODE});
    write_reg(REG_CAPACITY, {16'd0, CAPACITY_RESET});
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hfb, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hbf, 1'b1);

    // Decode: skipped junk, pad ends decoding, later text ignored
    wait_idle();
    write_reg(REG_DIRECTION, 32'd1);
    send_text("TW-E=Q!", 1'b1);
    // NUL ends decoding
    send_text("Zm", 1'b0);
    send_item(NUL_CHAR, 1'b0);
    send_item("9", 1'b1);
    // Top sextets, closing on a data byte
    send_text("//+", 1'b1);

    // Zero capacity: overflow on the first byte
    wait_idle();
    write_reg(REG_CAPACITY, 32'd0);
    send_text("AB", 1'b1);

    // Direction flipped mid-stream on shared state
    wait_idle();
    write_reg(REG_CAPACITY, {16'd0, CAPACITY_RESET});
    write_reg(REG_DIRECTION, {31'd0, DIR_ENCODE});
    send_item(8'h4d, 1'b0);
    wait_idle();
    write_reg(REG_DIRECTION, 32'd1);
    send_text("T", 1'b1);

    // Random streams with both sides idling
    run_streams(90);

    // Back-pressure: receiver holds off while the sender streams nonstop
    wait_idle();
    write_reg(REG_DIRECTION, {31'd0, DIR_ENCODE});
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 150;
    for (int i = 0; i < 40; i++) begin
      send_item(8'($urandom), i == 39);
    end
    wait_idle();

    // Full rate, then one side idling at a time
    rx_idle_en = 1'b0;
    run_streams(60);
    tx_idle_en = 1'b1;
    run_streams(30);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    run_streams(30);

    // Drain and let any stray result show up
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- base64_stream_codec.f -----
src/b64_pkg.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_stream_codec.sv
sim/testbench.sv
